/* rtl/core/orl_pkg.sv */
package orl_pkg;

    // Command codes carried by the opcode field.
    typedef enum logic [3:0] {
        OP_INS_HEAD  = 4'd0,
        OP_INS_TAIL  = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_REM_HEAD  = 4'd3,
        OP_REM_TAIL  = 4'd4,
        OP_REM_AT    = 4'd5,
        OP_REM_KEY   = 4'd6,
        OP_FIND_KEY  = 4'd7,
        OP_READ_AT   = 4'd8,
        OP_HAS_KEY   = 4'd9,
        OP_COUNT_KEY = 4'd10,
        OP_CLEAR     = 4'd11
    } opcode_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADPOS = 3'd3,
        ST_NOKEY  = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FIN,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic scan_step;
        logic finish;
        logic push;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_needed;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/core/orl_ctrl.sv */
module orl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  orl_pkg::dp_stat_t stat,
    output orl_pkg::ctl_cmd_t cmd
);
    import orl_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = stat.scan_needed ? S_SCAN : S_RESP;
            end
            S_SCAN: begin
                if (stat.scan_last) state_next = S_FIN;
            end
            S_FIN: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            S_EXEC: cmd.exec      = 1'b1;
            S_SCAN: cmd.scan_step = 1'b1;
            S_FIN:  cmd.finish    = 1'b1;
            S_RESP: cmd.push      = stat.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/orl_datapath.sv */
module orl_datapath #(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [3:0]         s_opcode,
    input  logic signed [31:0] s_entry_key,
    input  logic [31:0]        s_entry_payload,
    input  logic [4:0]         s_position,
    input  orl_pkg::ctl_cmd_t  cmd,
    output orl_pkg::dp_stat_t  stat,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_found_key,
    output logic [31:0]        m_found_payload,
    output logic [4:0]         m_match_count,
    output logic [4:0]         m_list_count
);
    import orl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Record cells; only entries below the count reach a result.
    logic [31:0] key_reg [DEPTH];
    logic [31:0] pay_reg [DEPTH];

    logic [CW-1:0] cnt_reg;
    logic [3:0]    op_reg;
    logic [31:0]   ckey_reg;
    logic [31:0]   cpay_reg;
    logic [4:0]    pos_reg;

    // Scan state.
    logic [CW-1:0] rd_reg;
    logic [CW-1:0] wr_reg;
    logic [CW-1:0] mcnt_reg;
    logic          found_reg;
    logic [31:0]   sk_reg;
    logic [31:0]   sp_reg;

    // Pending result.
    logic [2:0]    res_st_reg;
    logic [31:0]   res_fk_reg;
    logic [31:0]   res_fp_reg;
    logic [CW-1:0] res_mc_reg;

    logic          out_valid_reg;
    logic [2:0]    out_st_reg;
    logic [31:0]   out_fk_reg;
    logic [31:0]   out_fp_reg;
    logic [4:0]    out_mc_reg;
    logic [4:0]    out_lc_reg;

    // Combinational command decode.
    logic          is_key_op;
    logic          is_empty;
    logic          is_full;
    logic          do_ins;
    logic          do_rem;
    logic          do_clr;
    logic [IW-1:0] ins_idx;
    logic [IW-1:0] rem_idx;
    logic [2:0]    ex_st;
    logic [31:0]   ex_fk;
    logic [31:0]   ex_fp;
    logic          pos_ge_cnt;
    logic          pos_gt_cnt;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;
    logic          hit;

    always_comb begin
        is_key_op  = (op_reg == OP_REM_KEY) || (op_reg == OP_FIND_KEY) ||
                     (op_reg == OP_HAS_KEY) || (op_reg == OP_COUNT_KEY);
        is_empty   = (cnt_reg == '0);
        is_full    = (32'(cnt_reg) == DEPTH);
        pos_ge_cnt = (32'(pos_reg) >= 32'(cnt_reg));
        pos_gt_cnt = (32'(pos_reg) > 32'(cnt_reg));
        do_ins     = 1'b0;
        do_rem     = 1'b0;
        do_clr     = 1'b0;
        ins_idx    = '0;
        rem_idx    = '0;
        ex_st      = ST_OK;
        ex_fk      = '0;
        ex_fp      = '0;
        case (op_reg)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
                if (is_full) begin
                    ex_st = ST_FULL;
                end else if (op_reg == OP_INS_AT && pos_gt_cnt) begin
                    ex_st = ST_BADPOS;
                end else begin
                    do_ins  = 1'b1;
                    ins_idx = (op_reg == OP_INS_HEAD) ? '0 :
                              (op_reg == OP_INS_TAIL) ? IW'(cnt_reg) : IW'(pos_reg);
                end
            end
            OP_REM_HEAD, OP_REM_TAIL: begin
                if (is_empty) begin
                    ex_st = ST_EMPTY;
                end else begin
                    do_rem  = 1'b1;
                    rem_idx = (op_reg == OP_REM_HEAD) ? '0 : IW'(cnt_reg - 1'b1);
                end
            end
            OP_REM_AT: begin
                if (pos_ge_cnt) begin
                    ex_st = ST_BADPOS;
                end else begin
                    do_rem  = 1'b1;
                    rem_idx = IW'(pos_reg);
                end
            end
            OP_READ_AT: begin
                if (is_empty) begin
                    ex_st = ST_EMPTY;
                end else if (pos_ge_cnt) begin
                    ex_st = ST_BADPOS;
                end else begin
                    ex_fk = key_reg[IW'(pos_reg)];
                    ex_fp = pay_reg[IW'(pos_reg)];
                end
            end
            OP_REM_KEY, OP_FIND_KEY, OP_HAS_KEY, OP_COUNT_KEY: begin
                if (is_empty) ex_st = ST_EMPTY;
            end
            OP_CLEAR: begin
                do_clr = 1'b1;
            end
            default: begin
                ex_st = ST_OK;
            end
        endcase
    end

    assign rd_idx = IW'(rd_reg);
    assign wr_idx = IW'(wr_reg);
    assign hit    = (key_reg[rd_idx] == ckey_reg);

    assign stat.scan_needed = is_key_op && !is_empty;
    assign stat.scan_last   = (rd_reg == cnt_reg - 1'b1);
    assign stat.out_free    = !out_valid_reg || m_ready;

    // Record cells: shift up on insert, down on remove, compact on key removal.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (cmd.exec && do_ins) begin
                if (IW'(i) == ins_idx) begin
                    key_reg[i] <= ckey_reg;
                    pay_reg[i] <= cpay_reg;
                end else if (i > 0 && IW'(i) > ins_idx) begin
                    key_reg[i] <= key_reg[(i > 0) ? i - 1 : 0];
                    pay_reg[i] <= pay_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (cmd.exec && do_rem) begin
                if (i < DEPTH - 1 && IW'(i) >= rem_idx) begin
                    key_reg[i] <= key_reg[(i < DEPTH - 1) ? i + 1 : i];
                    pay_reg[i] <= pay_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end else if (cmd.scan_step && op_reg == OP_REM_KEY && !hit
                         && IW'(i) == wr_idx) begin
                key_reg[i] <= key_reg[rd_idx];
                pay_reg[i] <= pay_reg[rd_idx];
            end
        end
    end

    // Command capture, scan state and pending result.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_opcode;
            ckey_reg <= s_entry_key;
            cpay_reg <= s_entry_payload;
            pos_reg  <= s_position;
        end
        if (cmd.exec) begin
            rd_reg     <= '0;
            wr_reg     <= '0;
            mcnt_reg   <= '0;
            found_reg  <= 1'b0;
            sk_reg     <= '0;
            sp_reg     <= '0;
            res_st_reg <= ex_st;
            res_fk_reg <= ex_fk;
            res_fp_reg <= ex_fp;
            res_mc_reg <= '0;
        end
        if (cmd.scan_step) begin
            rd_reg <= rd_reg + 1'b1;
            if (hit) begin
                mcnt_reg <= mcnt_reg + 1'b1;
                if (!found_reg) begin
                    found_reg <= 1'b1;
                    sk_reg    <= key_reg[rd_idx];
                    sp_reg    <= pay_reg[rd_idx];
                end
            end else begin
                wr_reg <= wr_reg + 1'b1;
            end
        end
        if (cmd.finish) begin
            case (op_reg)
                OP_REM_KEY, OP_HAS_KEY: begin
                    res_st_reg <= found_reg ? ST_OK : ST_NOKEY;
                end
                OP_FIND_KEY: begin
                    res_st_reg <= found_reg ? ST_OK : ST_NOKEY;
                    if (found_reg) begin
                        res_fk_reg <= sk_reg;
                        res_fp_reg <= sp_reg;
                    end
                end
                OP_COUNT_KEY: begin
                    res_st_reg <= ST_OK;
                    res_mc_reg <= mcnt_reg;
                end
                default: begin
                    res_st_reg <= ST_OK;
                end
            endcase
        end
    end

    // Record count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.exec && do_ins) begin
            cnt_reg <= cnt_reg + 1'b1;
        end else if (cmd.exec && do_rem) begin
            cnt_reg <= cnt_reg - 1'b1;
        end else if (cmd.exec && do_clr) begin
            cnt_reg <= '0;
        end else if (cmd.finish && op_reg == OP_REM_KEY) begin
            cnt_reg <= wr_reg;
        end
    end

    // Output register; holds the result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_st_reg <= res_st_reg;
            out_fk_reg <= res_fk_reg;
            out_fp_reg <= res_fp_reg;
            out_mc_reg <= 5'(res_mc_reg);
            out_lc_reg <= 5'(cnt_reg);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_st_reg;
    assign m_found_key     = out_fk_reg;
    assign m_found_payload = out_fp_reg;
    assign m_match_count   = out_mc_reg;
    assign m_list_count    = out_lc_reg;

endmodule

/* rtl/core/ordered_record_list.sv */
// Ordered list of up to DEPTH records, each a 32-bit key and a 32-bit payload,
// kept packed from position 0.
// Input channel (s_valid/s_ready) carries one request: an opcode with key,
// payload and position. Output channel (m_valid/m_ready) returns exactly one
// result per request: status, found key and payload, match count and the
// record count after the request.
// Head, tail and positional requests, reads and clear go from EXEC to RESP;
// a new request is accepted only after the last one's result is pushed.
// Key requests (remove, find, test, count by key) go from EXEC through SCAN
// and FIN to RESP, walking the list one record a cycle through the scan read
// index; on an empty list they skip the walk.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls with a second result ready, the block
// holds that result and accepts nothing more until the first is taken.
// Reset empties the list; record storage is not cleared and needs no sweep.
module ordered_record_list #(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_opcode,
    input  logic signed [31:0] s_entry_key,
    input  logic [31:0]        s_entry_payload,
    input  logic [4:0]         s_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_found_key,
    output logic [31:0]        m_found_payload,
    output logic [4:0]         m_match_count,
    output logic [4:0]         m_list_count
);
    import orl_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    orl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    orl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_opcode        (s_opcode),
        .s_entry_key     (s_entry_key),
        .s_entry_payload (s_entry_payload),
        .s_position      (s_position),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_key     (m_found_key),
        .m_found_payload (m_found_payload),
        .m_match_count   (m_match_count),
        .m_list_count    (m_list_count)
    );

endmodule

/* bench/orl_checker.sv */
`timescale 1ns / 1ps

module orl_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [3:0]         s_opcode,
    input  logic signed [31:0] s_entry_key,
    input  logic [31:0]        s_entry_payload,
    input  logic [4:0]         s_position,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [2:0]         m_status,
    input  logic signed [31:0] m_found_key,
    input  logic [31:0]        m_found_payload,
    input  logic [4:0]         m_match_count,
    input  logic [4:0]         m_list_count,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count
);
    import orl_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        status_t     status;
        logic [31:0] found_key;
        logic [31:0] found_payload;
        logic [4:0]  match_count;
        logic [4:0]  list_count;
    } list_result_t;

    // Shadow copy of the list contents.
    logic [31:0] shadow_keys [DEPTH];
    logic [31:0] shadow_pays [DEPTH];
    int          shadow_count;
    list_result_t expected_results [$];

    // Opens a gap at slot and stores the record there.
    function automatic void shadow_insert(int slot, logic [31:0] k, logic [31:0] p);
        for (int i = shadow_count; i > slot; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pays[i] = shadow_pays[i-1];
        end
        shadow_keys[slot] = k;
        shadow_pays[slot] = p;
        shadow_count++;
    endfunction

    // Removes the record at slot and closes the gap.
    function automatic void shadow_remove(int slot);
        for (int i = slot; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_pays[i] = shadow_pays[i+1];
        end
        shadow_count--;
    endfunction

    // Applies one request to the shadow list and returns the result it gives.
    function automatic list_result_t apply_request(logic [3:0] op, logic [31:0] k,
                                                   logic [31:0] p, logic [4:0] pos);
        list_result_t r;
        int hit;
        int w;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        case (op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (op == OP_INS_AT && pos > shadow_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    shadow_insert(op == OP_INS_HEAD ? 0 :
                                  op == OP_INS_TAIL ? shadow_count : int'(pos), k, p);
                end
            end
            OP_REM_HEAD, OP_REM_TAIL: begin
                if (shadow_count == 0) r.status = ST_EMPTY;
                else shadow_remove(op == OP_REM_HEAD ? 0 : shadow_count - 1);
            end
            OP_REM_AT: begin
                if (pos >= shadow_count) r.status = ST_BADPOS;
                else shadow_remove(int'(pos));
            end
            OP_REM_KEY: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    w = 0;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow_keys[i] != k) begin
                            shadow_keys[w] = shadow_keys[i];
                            shadow_pays[w] = shadow_pays[i];
                            w++;
                        end
                    end
                    if (w == shadow_count) r.status = ST_NOKEY;
                    shadow_count = w;
                end
            end
            OP_FIND_KEY, OP_HAS_KEY: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = shadow_count - 1; i >= 0; i--)
                        if (shadow_keys[i] == k) hit = i;
                    if (hit < 0) begin
                        r.status = ST_NOKEY;
                    end else if (op == OP_FIND_KEY) begin
                        r.found_key = shadow_keys[hit];
                        r.found_payload = shadow_pays[hit];
                    end
                end
            end
            OP_READ_AT: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= shadow_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.found_key = shadow_keys[pos];
                    r.found_payload = shadow_pays[pos];
                end
            end
            OP_COUNT_KEY: begin
                if (shadow_count == 0) r.status = ST_EMPTY;
                else for (int i = 0; i < shadow_count; i++)
                    if (shadow_keys[i] == k) r.match_count++;
            end
            OP_CLEAR: shadow_count = 0;
            default: ;
        endcase
        r.list_count = 5'(shadow_count);
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            fail_count <= 0;
            result_count <= 0;
            expected_results.delete();
            for (int i = 0; i < DEPTH; i++) begin
                shadow_keys[i] = '0;
                shadow_pays[i] = '0;
            end
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(apply_request(s_opcode, s_entry_key,
                                                         s_entry_payload, s_position));
            if (m_valid && m_ready) begin
                got = {status_t'(m_status), m_found_key, m_found_payload,
                       m_match_count, m_list_count};
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR %0t: result with no request pending: %p", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("ERROR %0t: expected %p, got %p", $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* bench/tb_ordered_record_list.sv */
`timescale 1ns / 1ps

module tb_ordered_record_list;
    import orl_pkg::*;

    localparam int RANDOM_ITEMS = 1030;
    localparam int CYCLE_LIMIT  = 400000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [3:0]         s_opcode;
    logic signed [31:0] s_entry_key;
    logic [31:0]        s_entry_payload;
    logic [4:0]         s_position;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic signed [31:0] m_found_key;
    logic [31:0]        m_found_payload;
    logic [4:0]         m_match_count;
    logic [4:0]         m_list_count;
    int                 fail_count;
    int                 pending_count;
    int                 result_count;
    int                 cycle_count;
    bit                 long_stall;
    int                 sent_count;
    logic [31:0]        key_pool [4];

    ordered_record_list #(.DEPTH(16)) u_top (.*);

    orl_checker u_checker (.*);

    // Clock: 4 ns period.
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Cycle counter with a hard stop.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_ordered_record_list: done, errors");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_stall) begin
                m_ready <= 1'b0;
                for (int i = 0; i < 200; i++) @(negedge aclk);
                long_stall = 1'b0;
            end
            n = gap_length();
            if (n > 0 && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                for (int i = 1; i < n; i++) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one request and waits for it to be accepted.
    task automatic send_request(logic [3:0] op, logic [31:0] k, logic [31:0] p,
                                logic [4:0] pos);
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_entry_key     <= k;
        s_entry_payload <= p;
        s_position      <= pos;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent_count++;
    endtask

    task automatic idle_sender(int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // Random request, biased to a pool of four keys that recur.
    task automatic random_request();
        int r;
        logic [3:0] op;
        logic [31:0] k;
        logic [4:0] pos;
        r = $urandom_range(0, 99);
        if (r < 14) op = OP_INS_HEAD;
        else if (r < 30) op = OP_INS_TAIL;
        else if (r < 44) op = OP_INS_AT;
        else if (r < 97) op = 4'($urandom_range(3, 15));
        else op = OP_CLEAR;
        k = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 3)];
        pos = ($urandom_range(0, 4) == 0) ? 5'($urandom()) :
              5'($urandom_range(0, m_list_count + 1));
        send_request(op, k, $urandom(), pos);
    endtask

    // Stimulus.
    initial begin
        s_valid = 1'b0;
        s_opcode = '0;
        s_entry_key = '0;
        s_entry_payload = '0;
        s_position = '0;
        aresetn = 1'b0;
        cycle_count = 0;
        long_stall = 1'b0;
        sent_count = 0;
        for (int i = 0; i < 4; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty list cases, extremes, full list, key removal.
        send_request(OP_REM_HEAD, 0, 0, 0);
        send_request(OP_REM_TAIL, 0, 0, 0);
        send_request(OP_REM_AT, 0, 0, 0);
        send_request(OP_READ_AT, 0, 0, 0);
        send_request(OP_FIND_KEY, 0, 0, 0);
        send_request(OP_HAS_KEY, 0, 0, 0);
        send_request(OP_COUNT_KEY, 0, 0, 0);
        send_request(OP_REM_KEY, 0, 0, 0);
        send_request(OP_INS_AT, 32'h8000_0000, 32'hFFFF_FFFF, 5'd1);
        send_request(OP_INS_AT, 32'h8000_0000, 32'hFFFF_FFFF, 5'd0);
        send_request(OP_INS_HEAD, 32'h7FFF_FFFF, 32'h0, 0);
        send_request(OP_INS_TAIL, 32'h8000_0000, 32'h1234_5678, 0);
        for (int i = 0; i < 14; i++)
            send_request(OP_INS_AT, 32'hFFFF_FFFF, 32'(i), 5'(i % 3));
        send_request(OP_INS_TAIL, 0, 0, 0);
        send_request(OP_INS_AT, 0, 0, 5'd31);
        send_request(OP_READ_AT, 0, 0, 5'd15);
        send_request(OP_READ_AT, 0, 0, 5'd16);
        send_request(OP_REM_AT, 0, 0, 5'd16);
        send_request(OP_FIND_KEY, 32'h8000_0000, 0, 0);
        send_request(OP_COUNT_KEY, 32'hFFFF_FFFF, 0, 0);
        send_request(OP_HAS_KEY, 32'h1, 0, 0);
        send_request(OP_REM_KEY, 32'h8000_0000, 0, 0);
        send_request(OP_REM_KEY, 32'h8000_0000, 0, 0);
        send_request(4'd15, 0, 0, 0);
        send_request(OP_CLEAR, 0, 0, 0);

        // Random requests, with one long receiver stall and one full drain.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 300) long_stall = 1'b1;
            if (i == 600) begin
                s_valid <= 1'b0;
                while (pending_count != 0) @(negedge aclk);
            end
            if ($urandom_range(0, 2) == 0) idle_sender(gap_length());
            random_request();
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        $display("Sent %0d requests and checked %0d results over all commands,",
                 sent_count, result_count);
        $display("including full, empty and out-of-range cases and a long output stall.");
        if (fail_count == 0) begin
            $display("tb_ordered_record_list: done, clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("tb_ordered_record_list: done, errors");
        end
        $finish;
    end

endmodule
